// ===== rtl/core/hv_contactor_precharge_sequencer_macros.svh =====
// assertion macros shared by the contactor sequencer rtl
`ifndef HV_CONTACTOR_PRECHARGE_SEQUENCER_MACROS_SVH
`define HV_CONTACTOR_PRECHARGE_SEQUENCER_MACROS_SVH

// same-cycle implication, checked outside reset
`define HVCS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hvcs check failed: same-cycle rule");

// next-cycle implication, checked outside reset
`define HVCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hvcs check failed: next-cycle rule");

`endif

// ===== rtl/core/hvcs_pkg.sv =====
// types, codes and reset values of the contactor sequencer
package hvcs_pkg;

	localparam int TIME_WIDTH_DEF = 32;
	localparam int VOLT_WIDTH_DEF = 14;
	localparam int APB_ADDR_W     = 5;
	localparam int APB_DATA_W     = 32;

	// pack voltage above which the ratio gate applies (50.0 V in 0.1 V units)
	localparam int PACK_LOW_DV = 500;

	typedef enum logic [2:0] {
		ST_OPEN   = 3'd0,
		ST_PRE    = 3'd1,
		ST_MAIN   = 3'd2,
		ST_CLOSED = 3'd3,
		ST_FAULT  = 3'd4
	} seq_state_t;

	typedef enum logic [2:0] {
		CAUSE_NONE    = 3'd0,
		CAUSE_LOST    = 3'd1,
		CAUSE_UNDER   = 3'd2,
		CAUSE_OVER    = 3'd3,
		CAUSE_TIMEOUT = 3'd4,
		CAUSE_TRIP    = 3'd5
	} cause_t;

	localparam logic [1:0] CMD_TICK    = 2'd0;
	localparam logic [1:0] CMD_DEADMAN = 2'd1;
	localparam logic [1:0] CMD_TRIP    = 2'd2;

	localparam logic [2:0] REG_MODE        = 3'd0;
	localparam logic [2:0] REG_CELL_UNDER  = 3'd1;
	localparam logic [2:0] REG_CELL_OVER   = 3'd2;
	localparam logic [2:0] REG_GATE_MIN    = 3'd3;
	localparam logic [2:0] REG_PRE_LIMIT   = 3'd4;
	localparam logic [2:0] REG_OVERLAP     = 3'd5;
	localparam logic [2:0] REG_GATE_RATIO  = 3'd6;
	localparam logic [2:0] REG_GATE_MINBUS = 3'd7;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] cell_under_mv;
		logic [15:0] cell_over_mv;
		logic [15:0] gate_min_ms;
		logic [15:0] precharge_limit_ms;
		logic [15:0] overlap_ms;
		logic [7:0]  gate_ratio;
		logic [13:0] gate_min_bus_dv;
	} hvcs_cfg_t;

	localparam hvcs_cfg_t CFG_RESET = '{
		mode:               2'd0,
		cell_under_mv:      16'd3000,
		cell_over_mv:       16'd4200,
		gate_min_ms:        16'd500,
		precharge_limit_ms: 16'd5000,
		overlap_ms:         16'd100,
		gate_ratio:         8'd230,
		gate_min_bus_dv:    14'd500
	};

	typedef struct packed {
		seq_state_t seq_state;
		logic       drive_precharge;
		logic       drive_main_pos;
		logic       drive_main_neg;
		logic       deadman_now;
		cause_t     fault_cause;
	} hvcs_res_t;

endpackage

// ===== rtl/core/hvcs_step.sv =====
// sequencer state registers and the next-state logic for one word
module hvcs_step #(
	parameter int TIME_WIDTH = hvcs_pkg::TIME_WIDTH_DEF,
	parameter int VOLT_WIDTH = hvcs_pkg::VOLT_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  hvcs_pkg::hvcs_cfg_t   cfg,
	input  logic                  fire,
	input  logic [1:0]            command,
	input  logic                  deadman_on,
	input  logic [TIME_WIDTH-1:0] now_ms,
	input  logic                  pack_stable,
	input  logic [15:0]           min_cell_mv,
	input  logic [15:0]           max_cell_mv,
	input  logic [VOLT_WIDTH-1:0] pack_dv,
	input  logic [VOLT_WIDTH-1:0] bus_dv,
	output hvcs_pkg::hvcs_res_t   res
);
	import hvcs_pkg::*;

	localparam int PROD_W = VOLT_WIDTH + 8;

	typedef struct packed {
		seq_state_t            fsm;
		logic [TIME_WIDTH-1:0] entry;
		cause_t                code;
	} ctx_t;

	// entry time and cause change only on a real state change
	function automatic ctx_t go_to(ctx_t c, seq_state_t nxt, cause_t why,
			logic [TIME_WIDTH-1:0] now);
		ctx_t r;
		r = c;
		if (nxt != c.fsm) begin
			r.fsm   = nxt;
			r.entry = now;
			if (nxt == ST_FAULT) begin
				r.code = why;
			end else if (nxt == ST_OPEN) begin
				r.code = CAUSE_NONE;
			end
		end
		return r;
	endfunction

	ctx_t                  cur_q;
	logic                  deadman_q;
	logic                  saw_stable_q;

	ctx_t                  nxt;
	logic                  deadman_n;
	logic                  saw_stable_n;
	logic [TIME_WIDTH-1:0] elapsed;
	logic [PROD_W-1:0]     bus_scaled;
	logic [PROD_W-1:0]     pack_scaled;
	logic                  ratio_ok;
	logic                  gate_ok;
	logic                  live;

	// gate comparison, independent of state
	always_comb begin
		bus_scaled  = {bus_dv, 8'd0};
		pack_scaled = PROD_W'(pack_dv) * PROD_W'(cfg.gate_ratio);
		if (16'(pack_dv) > 16'(PACK_LOW_DV)) begin
			ratio_ok = bus_scaled >= pack_scaled;
		end else begin
			ratio_ok = 16'(bus_dv) >= 16'(cfg.gate_min_bus_dv);
		end
	end

	always_comb begin
		nxt          = cur_q;
		deadman_n    = deadman_q;
		saw_stable_n = saw_stable_q;
		elapsed      = '0;
		gate_ok      = 1'b0;
		live         = 1'b0;
		unique case (command)
			CMD_TICK: begin
				if (!deadman_q && nxt.fsm != ST_OPEN && nxt.fsm != ST_FAULT) begin
					nxt = go_to(nxt, ST_OPEN, CAUSE_NONE, now_ms);
				end
				live = nxt.fsm != ST_OPEN && nxt.fsm != ST_FAULT;
				if (live) begin
					if (!pack_stable) begin
						if (saw_stable_q) begin
							nxt = go_to(nxt, ST_FAULT, CAUSE_LOST, now_ms);
						end
					end else begin
						saw_stable_n = 1'b1;
						if (min_cell_mv != 16'd0 && min_cell_mv < cfg.cell_under_mv) begin
							nxt = go_to(nxt, ST_FAULT, CAUSE_UNDER, now_ms);
						end else if (max_cell_mv > cfg.cell_over_mv) begin
							nxt = go_to(nxt, ST_FAULT, CAUSE_OVER, now_ms);
						end
					end
				end
				elapsed = now_ms - nxt.entry;
				gate_ok = cfg.mode[0] && ratio_ok
					&& elapsed >= TIME_WIDTH'(cfg.gate_min_ms);
				unique case (nxt.fsm)
					ST_OPEN: begin
						if (deadman_q) begin
							nxt = go_to(nxt, ST_PRE, CAUSE_NONE, now_ms);
						end
					end
					ST_PRE: begin
						if (!deadman_q) begin
							nxt = go_to(nxt, ST_OPEN, CAUSE_NONE, now_ms);
						end else if (gate_ok) begin
							nxt = go_to(nxt, ST_MAIN, CAUSE_NONE, now_ms);
						end else if (elapsed >= TIME_WIDTH'(cfg.precharge_limit_ms)) begin
							if (cfg.mode[0]) begin
								nxt = go_to(nxt, ST_FAULT, CAUSE_TIMEOUT, now_ms);
							end else begin
								nxt = go_to(nxt, ST_MAIN, CAUSE_NONE, now_ms);
							end
						end
					end
					ST_MAIN: begin
						if (!deadman_q) begin
							nxt = go_to(nxt, ST_OPEN, CAUSE_NONE, now_ms);
						end else if (elapsed >= TIME_WIDTH'(cfg.overlap_ms)) begin
							nxt = go_to(nxt, ST_CLOSED, CAUSE_NONE, now_ms);
						end
					end
					ST_CLOSED: begin
						if (!deadman_q) begin
							nxt = go_to(nxt, ST_OPEN, CAUSE_NONE, now_ms);
						end
					end
					default: ;
				endcase
			end
			CMD_DEADMAN: begin
				deadman_n = deadman_on;
				if (!deadman_on) begin
					nxt = go_to(nxt, ST_OPEN, CAUSE_NONE, now_ms);
				end
			end
			CMD_TRIP: begin
				nxt = go_to(nxt, ST_FAULT, CAUSE_TRIP, now_ms);
			end
			default: ;
		endcase
	end

	always_comb begin
		res.seq_state       = nxt.fsm;
		res.drive_precharge = cfg.mode[1] && (nxt.fsm == ST_PRE || nxt.fsm == ST_MAIN);
		res.drive_main_pos  = cfg.mode[1] && (nxt.fsm == ST_MAIN || nxt.fsm == ST_CLOSED);
		res.drive_main_neg  = res.drive_main_pos;
		res.deadman_now     = deadman_n;
		res.fault_cause     = nxt.code;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q.fsm    <= ST_OPEN;
			cur_q.entry  <= '0;
			cur_q.code   <= CAUSE_NONE;
			deadman_q    <= 1'b0;
			saw_stable_q <= 1'b0;
		end else if (fire) begin
			cur_q        <= nxt;
			deadman_q    <= deadman_n;
			saw_stable_q <= saw_stable_n;
		end
	end

endmodule

// ===== rtl/core/hv_contactor_precharge_sequencer.sv =====
// high-voltage contactor precharge sequencer, top level
// input words are registered in s1; their result words are registered onto m_tdata
// one word per cycle unless m_tready stalls; each word sees the state the previous one left
// the whole state update is one pass of compare logic between s1 register and result register
// reset (arst_n low, asynchronous): state open, dead-man off, no fault, entry time 0,
// registers back to their default values, both stream sides empty
`include "hv_contactor_precharge_sequencer_macros.svh"

module hv_contactor_precharge_sequencer #(
	parameter int TIME_WIDTH = hvcs_pkg::TIME_WIDTH_DEF,
	parameter int VOLT_WIDTH = hvcs_pkg::VOLT_WIDTH_DEF,
	parameter int IN_BITS    = 2 + TIME_WIDTH + 32 + 2 * VOLT_WIDTH,
	parameter int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// input stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// deadman_on, now_ms, pack_stable, min_cell_mv, max_cell_mv, pack_dv, bus_dv
	input  logic [IN_DATA_W-1:0]              s_tdata,
	// command
	input  logic [1:0]                        s_tuser,
	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// seq_state, drive_precharge, drive_main_pos, drive_main_neg, deadman_now,
	// fault_cause, zero fill
	output logic [15:0]                       m_tdata,
	// register port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [hvcs_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [hvcs_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [hvcs_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready
);
	import hvcs_pkg::*;

	// field offsets inside s_tdata
	localparam int OFS_NOW    = 1;
	localparam int OFS_STABLE = OFS_NOW + TIME_WIDTH;
	localparam int OFS_MIN    = OFS_STABLE + 1;
	localparam int OFS_MAX    = OFS_MIN + 16;
	localparam int OFS_PACK   = OFS_MAX + 16;
	localparam int OFS_BUS    = OFS_PACK + VOLT_WIDTH;

	// ---------------- register file ----------------
	hvcs_cfg_t  cfg_q;
	logic       reg_wr;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign reg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (reg_wr) begin
			unique case (reg_idx)
				REG_MODE:        cfg_q.mode               <= pwdata[1:0];
				REG_CELL_UNDER:  cfg_q.cell_under_mv      <= pwdata[15:0];
				REG_CELL_OVER:   cfg_q.cell_over_mv       <= pwdata[15:0];
				REG_GATE_MIN:    cfg_q.gate_min_ms        <= pwdata[15:0];
				REG_PRE_LIMIT:   cfg_q.precharge_limit_ms <= pwdata[15:0];
				REG_OVERLAP:     cfg_q.overlap_ms         <= pwdata[15:0];
				REG_GATE_RATIO:  cfg_q.gate_ratio         <= pwdata[7:0];
				REG_GATE_MINBUS: cfg_q.gate_min_bus_dv    <= pwdata[13:0];
				default: ;
			endcase
		end
	end

	// read mux, zero extended
	always_comb begin
		unique case (reg_idx)
			REG_MODE:        prdata = APB_DATA_W'(cfg_q.mode);
			REG_CELL_UNDER:  prdata = APB_DATA_W'(cfg_q.cell_under_mv);
			REG_CELL_OVER:   prdata = APB_DATA_W'(cfg_q.cell_over_mv);
			REG_GATE_MIN:    prdata = APB_DATA_W'(cfg_q.gate_min_ms);
			REG_PRE_LIMIT:   prdata = APB_DATA_W'(cfg_q.precharge_limit_ms);
			REG_OVERLAP:     prdata = APB_DATA_W'(cfg_q.overlap_ms);
			REG_GATE_RATIO:  prdata = APB_DATA_W'(cfg_q.gate_ratio);
			REG_GATE_MINBUS: prdata = APB_DATA_W'(cfg_q.gate_min_bus_dv);
			default:         prdata = '0;
		endcase
	end

	// ---------------- input register (s1) ----------------
	logic                  valid_s1;
	logic [1:0]            command_s1;
	logic                  deadman_on_s1;
	logic [TIME_WIDTH-1:0] now_ms_s1;
	logic                  pack_stable_s1;
	logic [15:0]           min_cell_mv_s1;
	logic [15:0]           max_cell_mv_s1;
	logic [VOLT_WIDTH-1:0] pack_dv_s1;
	logic [VOLT_WIDTH-1:0] bus_dv_s1;

	logic                  out_valid_q;
	hvcs_res_t             out_res_q;
	hvcs_res_t             step_res;
	logic                  advance;
	logic                  fire;

	// result register free or being drained this cycle
	assign advance  = !out_valid_q || m_tready;
	// s1 empties whenever it can move forward, so a new word fits every cycle that advance is high
	assign s_tready = !valid_s1 || advance;
	assign fire     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			command_s1     <= s_tuser;
			deadman_on_s1  <= s_tdata[0];
			now_ms_s1      <= s_tdata[OFS_NOW +: TIME_WIDTH];
			pack_stable_s1 <= s_tdata[OFS_STABLE];
			min_cell_mv_s1 <= s_tdata[OFS_MIN +: 16];
			max_cell_mv_s1 <= s_tdata[OFS_MAX +: 16];
			pack_dv_s1     <= s_tdata[OFS_PACK +: VOLT_WIDTH];
			bus_dv_s1      <= s_tdata[OFS_BUS +: VOLT_WIDTH];
		end
	end

	// ---------------- sequencer state and next-state logic ----------------
	hvcs_step #(
		.TIME_WIDTH (TIME_WIDTH),
		.VOLT_WIDTH (VOLT_WIDTH)
	) u_step (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.fire        (fire),
		.command     (command_s1),
		.deadman_on  (deadman_on_s1),
		.now_ms      (now_ms_s1),
		.pack_stable (pack_stable_s1),
		.min_cell_mv (min_cell_mv_s1),
		.max_cell_mv (max_cell_mv_s1),
		.pack_dv     (pack_dv_s1),
		.bus_dv      (bus_dv_s1),
		.res         (step_res)
	);

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_res_q <= step_res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_res_q.fault_cause, out_res_q.deadman_now,
		out_res_q.drive_main_neg, out_res_q.drive_main_pos,
		out_res_q.drive_precharge, out_res_q.seq_state};

	// ---------------- checks ----------------
	// a cause is reported only together with the fault state
	`HVCS_ASSERT_NOW(a_cause_only_in_fault, clk, arst_n,
		out_valid_q && out_res_q.fault_cause != CAUSE_NONE, out_res_q.seq_state == ST_FAULT)
	// precharge and mains are on together only during the overlap state
	`HVCS_ASSERT_NOW(a_overlap_only_in_main, clk, arst_n,
		out_valid_q && out_res_q.drive_precharge && out_res_q.drive_main_pos,
		out_res_q.seq_state == ST_MAIN)
	// a word leaving s1 shows up as a valid result next cycle
	`HVCS_ASSERT_NEXT(a_fire_gives_result, clk, arst_n, fire, out_valid_q)
	// an empty result register never holds off the input side
	`HVCS_ASSERT_NOW(a_ready_when_drained, clk, arst_n, !out_valid_q, s_tready)

endmodule

// ===== dv/hv_contactor_precharge_sequencer_checker.sv =====
`timescale 1ns / 100ps
// checker that predicts and compares every result word of the contactor sequencer
module hv_contactor_precharge_sequencer_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [95:0]                     s_tdata,
	input  logic [1:0]                      s_tuser,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [15:0]                     m_tdata,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [hvcs_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [hvcs_pkg::APB_DATA_W-1:0] pwdata,
	input  logic                            pready,
	output int                              mismatches,
	output int                              pending,
	output int                              compared
);
	import hvcs_pkg::*;

	typedef struct {
		seq_state_t st;
		logic       pre;
		logic       pos_drive;
		logic       neg_drive;
		logic       dm;
		cause_t     cause;
	} coil_status_t;

	coil_status_t status_q[$];

	hvcs_cfg_t   regs;
	seq_state_t  seq;
	logic        dm_flag;
	logic        stable_seen;
	logic [31:0] entered_at;
	cause_t      cause_held;

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] exp_v);
		mismatches++;
		$display("%0t: %s mismatch, got %0h expected %0h", $time, field, got, exp_v);
	endtask

	function automatic void reset_sequencer();
		regs        = CFG_RESET;
		seq         = ST_OPEN;
		dm_flag     = 1'b0;
		stable_seen = 1'b0;
		entered_at  = '0;
		cause_held  = CAUSE_NONE;
		status_q.delete();
	endfunction

	// entry time and cause only move on a real state change
	function automatic void enter(input seq_state_t nxt, input cause_t why,
			input logic [31:0] now);
		if (nxt == seq)
			return;
		seq        = nxt;
		entered_at = now;
		if (nxt == ST_FAULT)
			cause_held = why;
		if (nxt == ST_OPEN)
			cause_held = CAUSE_NONE;
	endfunction

	function automatic coil_status_t step_sequencer(input logic [1:0] cmd,
			input logic [95:0] w);
		logic         on;
		logic [31:0]  now;
		logic         stable;
		logic [15:0]  mn;
		logic [15:0]  mx;
		logic [13:0]  pack;
		logic [13:0]  bus;
		logic [31:0]  elapsed;
		logic         gate;
		coil_status_t r;
		on     = w[0];
		now    = w[32:1];
		stable = w[33];
		mn     = w[49:34];
		mx     = w[65:50];
		pack   = w[79:66];
		bus    = w[93:80];
		case (cmd)
			CMD_TICK: begin
				if (!dm_flag && seq != ST_OPEN && seq != ST_FAULT)
					enter(ST_OPEN, CAUSE_NONE, now);
				// pack checks only while the sequence is active
				if (seq != ST_OPEN && seq != ST_FAULT) begin
					if (!stable) begin
						if (stable_seen)
							enter(ST_FAULT, CAUSE_LOST, now);
					end else begin
						stable_seen = 1'b1;
						if (mn != 16'd0 && mn < regs.cell_under_mv)
							enter(ST_FAULT, CAUSE_UNDER, now);
						else if (mx > regs.cell_over_mv)
							enter(ST_FAULT, CAUSE_OVER, now);
					end
				end
				elapsed = now - entered_at;
				gate = regs.mode[0] && elapsed >= 32'(regs.gate_min_ms) &&
					((pack > PACK_LOW_DV) ?
						((32'(bus) << 8) >= 32'(pack) * 32'(regs.gate_ratio)) :
						(bus >= regs.gate_min_bus_dv));
				case (seq)
					ST_OPEN: begin
						if (dm_flag)
							enter(ST_PRE, CAUSE_NONE, now);
					end
					ST_PRE: begin
						if (!dm_flag)
							enter(ST_OPEN, CAUSE_NONE, now);
						else if (gate)
							enter(ST_MAIN, CAUSE_NONE, now);
						else if (elapsed >= 32'(regs.precharge_limit_ms))
							enter(regs.mode[0] ? ST_FAULT : ST_MAIN, CAUSE_TIMEOUT, now);
					end
					ST_MAIN: begin
						if (!dm_flag)
							enter(ST_OPEN, CAUSE_NONE, now);
						else if (elapsed >= 32'(regs.overlap_ms))
							enter(ST_CLOSED, CAUSE_NONE, now);
					end
					ST_CLOSED: begin
						if (!dm_flag)
							enter(ST_OPEN, CAUSE_NONE, now);
					end
					default: ;
				endcase
			end
			CMD_DEADMAN: begin
				dm_flag = on;
				if (!on)
					enter(ST_OPEN, CAUSE_NONE, now);
			end
			CMD_TRIP: enter(ST_FAULT, CAUSE_TRIP, now);
			default: ;
		endcase
		r.st        = seq;
		r.pre       = regs.mode[1] & (seq == ST_PRE || seq == ST_MAIN);
		r.pos_drive = regs.mode[1] & (seq == ST_MAIN || seq == ST_CLOSED);
		r.neg_drive = r.pos_drive;
		r.dm        = dm_flag;
		r.cause     = cause_held;
		return r;
	endfunction

	always @(posedge clk) begin : watch
		coil_status_t exp_w;
		if (!arst_n) begin
			reset_sequencer();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_MODE:        regs.mode               = pwdata[1:0];
					REG_CELL_UNDER:  regs.cell_under_mv      = pwdata[15:0];
					REG_CELL_OVER:   regs.cell_over_mv       = pwdata[15:0];
					REG_GATE_MIN:    regs.gate_min_ms        = pwdata[15:0];
					REG_PRE_LIMIT:   regs.precharge_limit_ms = pwdata[15:0];
					REG_OVERLAP:     regs.overlap_ms         = pwdata[15:0];
					REG_GATE_RATIO:  regs.gate_ratio         = pwdata[7:0];
					REG_GATE_MINBUS: regs.gate_min_bus_dv    = pwdata[13:0];
					default: ;
				endcase
			end
			// older results leave before the new word's result is queued
			if (m_tvalid && m_tready) begin
				if (status_q.size() == 0) begin
					report_mismatch("unexpected result word", 32'(m_tdata), 32'd0);
				end else begin
					exp_w = status_q.pop_front();
					compared++;
					if (m_tdata[2:0] !== exp_w.st)
						report_mismatch("seq_state", 32'(m_tdata[2:0]), 32'(exp_w.st));
					if (m_tdata[3] !== exp_w.pre)
						report_mismatch("drive_precharge", 32'(m_tdata[3]), 32'(exp_w.pre));
					if (m_tdata[4] !== exp_w.pos_drive)
						report_mismatch("drive_main_pos", 32'(m_tdata[4]),
							32'(exp_w.pos_drive));
					if (m_tdata[5] !== exp_w.neg_drive)
						report_mismatch("drive_main_neg", 32'(m_tdata[5]),
							32'(exp_w.neg_drive));
					if (m_tdata[6] !== exp_w.dm)
						report_mismatch("deadman_now", 32'(m_tdata[6]), 32'(exp_w.dm));
					if (m_tdata[9:7] !== exp_w.cause)
						report_mismatch("fault_cause", 32'(m_tdata[9:7]), 32'(exp_w.cause));
					if (m_tdata[15:10] !== '0)
						report_mismatch("zero fill", 32'(m_tdata[15:10]), 32'd0);
				end
			end
			if (s_tvalid && s_tready)
				status_q.push_back(step_sequencer(s_tuser, s_tdata));
		end
		pending = status_q.size();
	end

endmodule

// ===== dv/hv_contactor_precharge_sequencer_tb.sv =====
`timescale 1ns / 100ps
// testbench top: stimulus, register settings and verdict for the contactor sequencer
module hv_contactor_precharge_sequencer_tb;
	import hvcs_pkg::*;

	// generous bound: every word waiting out the longest sender gap and receiver stall
	localparam int CYCLE_LIMIT     = 400000;
	localparam int RANDOM_PHASES   = 12;
	localparam int WORDS_PER_PHASE = 134;
	// command code the block has no meaning for; it must only report the state
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	// flavors of register settings
	localparam int SET_TYPICAL = 0;
	localparam int SET_ALL_MIN = 1;
	localparam int SET_ALL_MAX = 2;
	localparam int SET_RANDOM  = 3;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	// deadman_on, now_ms, pack_stable, min_cell_mv, max_cell_mv, pack_dv, bus_dv, zero fill
	logic [95:0]           s_tdata  = '0;
	// command
	logic [1:0]            s_tuser  = '0;
	logic                  m_tready = 1'b0;
	logic                  psel     = 1'b0;
	logic                  penable  = 1'b0;
	logic                  pwrite   = 1'b0;
	logic [APB_ADDR_W-1:0] paddr    = '0;
	logic [APB_DATA_W-1:0] pwdata   = '0;
	wire                   s_tready;
	wire                   m_tvalid;
	// seq_state, drive_precharge, drive_main_pos, drive_main_neg, deadman_now,
	// fault_cause, zero fill
	wire  [15:0]           m_tdata;
	wire  [APB_DATA_W-1:0] prdata;
	wire                   pready;

	int          mismatches;
	int          pending;
	int          compared;
	int          cycles = 0;
	int          words_sent = 0;
	int          settings_used = 0;
	int          snd_max = 3;
	int          rcv_max = 3;
	int          stall_left = 0;
	logic [31:0] clock_ms = 32'hFFFF_F000;
	hvcs_cfg_t   cfg_now = CFG_RESET;

	// setting flavor and mode per random phase; both extremes appear twice
	int         flavor_plan [RANDOM_PHASES] = '{0, 1, 0, 2, 0, 0, 3, 1, 2, 0, 0, 3};
	logic [1:0] mode_plan   [RANDOM_PHASES] = '{3, 3, 0, 3, 1, 2, 3, 0, 0, 3, 3, 1};

	hv_contactor_precharge_sequencer uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	hv_contactor_precharge_sequencer_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.mismatches (mismatches),
		.pending    (pending),
		.compared   (compared)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit: a hung handshake ends the run as a failure
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("cycle limit hit with %0d result words outstanding", pending);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// result side: after each accepted word, stall a random number of cycles
	always @(posedge clk) begin : receiver
		int n;
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
		end else if (m_tready) begin
			if (m_tvalid) begin
				n = $urandom_range(0, rcv_max);
				if (n != 0) begin
					m_tready <= 1'b0;
					stall_left = n;
				end
			end
		end else begin
			if (stall_left <= 1)
				m_tready <= 1'b1;
			if (stall_left > 0)
				stall_left = stall_left - 1;
		end
	end

	function automatic logic [95:0] pack_word(input logic on, input logic [31:0] now,
			input logic stable, input logic [15:0] mn, input logic [15:0] mx,
			input logic [13:0] pack, input logic [13:0] bus);
		return {2'b00, bus, pack, mx, mn, stable, now, on};
	endfunction

	// one word on the input side, with a random gap ahead of it
	task automatic send_word(input logic [1:0] cmd, input logic [95:0] data);
		int gap;
		gap = $urandom_range(0, snd_max);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= data;
		do @(posedge clk); while (!s_tready);
		words_sent++;
	endtask

	// sample word: time moves on by dt first
	task automatic tick(input logic [31:0] dt, input logic stable, input logic [15:0] mn,
			input logic [15:0] mx, input logic [13:0] pack, input logic [13:0] bus);
		clock_ms = clock_ms + dt;
		send_word(CMD_TICK, pack_word(1'($urandom_range(0, 1)), clock_ms, stable, mn, mx,
			pack, bus));
	endtask

	// dead-man or trip word at the current time; sample fields are don't-care
	task automatic issue_command(input logic [1:0] cmd, input logic on);
		send_word(cmd, pack_word(on, clock_ms, 1'($urandom_range(0, 1)), 16'($urandom),
			16'($urandom), 14'($urandom), 14'($urandom)));
	endtask

	// setup phase, then access phase, then the bus returns to idle
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// stop sending and let every outstanding result word come out
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// registers only change with the block idle
	task automatic apply_settings(input hvcs_cfg_t c);
		drain();
		write_reg(REG_MODE, 32'(c.mode));
		write_reg(REG_CELL_UNDER, 32'(c.cell_under_mv));
		write_reg(REG_CELL_OVER, 32'(c.cell_over_mv));
		write_reg(REG_GATE_MIN, 32'(c.gate_min_ms));
		write_reg(REG_PRE_LIMIT, 32'(c.precharge_limit_ms));
		write_reg(REG_OVERLAP, 32'(c.overlap_ms));
		write_reg(REG_GATE_RATIO, 32'(c.gate_ratio));
		write_reg(REG_GATE_MINBUS, 32'(c.gate_min_bus_dv));
		cfg_now = c;
		settings_used++;
	endtask

	function automatic hvcs_cfg_t random_settings(input int flavor, input logic [1:0] mode);
		hvcs_cfg_t c;
		case (flavor)
			SET_TYPICAL: begin
				c.cell_under_mv      = 16'($urandom_range(2800, 3200));
				c.cell_over_mv       = 16'($urandom_range(4000, 4300));
				c.gate_min_ms        = 16'($urandom_range(0, 300));
				c.precharge_limit_ms = 16'($urandom_range(100, 1500));
				c.overlap_ms         = 16'($urandom_range(0, 200));
				c.gate_ratio         = 8'($urandom);
				c.gate_min_bus_dv    = 14'($urandom);
			end
			SET_ALL_MIN: begin
				c = '0;
			end
			SET_ALL_MAX: begin
				c.cell_under_mv      = 16'hFFFF;
				c.cell_over_mv       = 16'hFFFF;
				c.gate_min_ms        = 16'hFFFF;
				c.precharge_limit_ms = 16'hFFFF;
				c.overlap_ms         = 16'hFFFF;
				c.gate_ratio         = 8'hFF;
				c.gate_min_bus_dv    = 14'h3FFF;
			end
			default: begin
				c = hvcs_cfg_t'({$urandom, $urandom, $urandom, $urandom});
			end
		endcase
		c.mode = mode;
		return c;
	endfunction

	// mostly well-formed sample words near the gate and cell limits, some noise
	task automatic random_word();
		int          pick;
		int          target;
		logic [15:0] mn;
		logic [15:0] mx;
		logic [13:0] pack;
		logic [13:0] bus;
		logic [31:0] dt;
		pick = $urandom_range(0, 99);
		if (pick < 5) begin
			// any command code, any field value, including a jump in time
			send_word(2'($urandom), {2'b00, 30'($urandom), $urandom, $urandom});
		end else if (pick < 13) begin
			issue_command(CMD_DEADMAN, $urandom_range(0, 3) != 0);
		end else if (pick < 15) begin
			issue_command(CMD_TRIP, 1'($urandom_range(0, 1)));
		end else begin
			mn = 16'($urandom_range(cfg_now.cell_over_mv, cfg_now.cell_under_mv));
			if ($urandom_range(0, 19) == 0)
				mn = $urandom_range(0, 1) ? 16'd0 : 16'($urandom);
			mx = 16'($urandom_range(cfg_now.cell_over_mv, mn));
			if ($urandom_range(0, 19) == 0)
				mx = 16'($urandom);
			pick = $urandom_range(0, 9);
			if (pick < 7)
				pack = 14'($urandom_range(PACK_LOW_DV + 1, 16383));
			else if (pick < 9)
				pack = 14'($urandom_range(0, PACK_LOW_DV));
			else
				pack = 14'($urandom);
			// bus close to the gate threshold half of the time
			if (pack > PACK_LOW_DV)
				target = (int'(pack) * int'(cfg_now.gate_ratio) + 255) / 256;
			else
				target = int'(cfg_now.gate_min_bus_dv);
			target = target + int'($urandom_range(0, 6)) - 3;
			if (target < 0)
				target = 0;
			if (target > 16383)
				target = 16383;
			bus = $urandom_range(0, 1) ? 14'(target) : 14'($urandom);
			pick = $urandom_range(0, 19);
			if (pick == 0)
				dt = $urandom;
			else if (pick < 4)
				dt = $urandom_range(0, 3);
			else
				dt = $urandom_range(0, cfg_now.precharge_limit_ms / 6 + 2);
			tick(dt, $urandom_range(0, 19) != 0, mn, mx, pack, bus);
		end
	endtask

	initial begin : stimulus
		hvcs_cfg_t c;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: timed precharge, coils not driven; time starts near the wrap
		tick(10, 1'b1, 16'd3500, 16'd3600, 14'd4000, 14'd0);      // open, dead-man off
		send_word(CMD_UNUSED, pack_word(1'b1, clock_ms, 1'b1, 16'hFFFF, 16'hFFFF,
			14'h3FFF, 14'h3FFF));                                 // unused code
		issue_command(CMD_TRIP, 1'b0);                            // trip from open
		issue_command(CMD_TRIP, 1'b0);                            // trip while faulted keeps cause
		issue_command(CMD_DEADMAN, 1'b1);                         // dead-man on, still faulted
		tick(10, 1'b0, 16'd0, 16'd0, 14'd0, 14'd0);
		issue_command(CMD_DEADMAN, 1'b0);                         // fault cleared to open
		issue_command(CMD_DEADMAN, 1'b1);
		tick(10, 1'b0, 16'd0, 16'd0, 14'd0, 14'd0);               // open to precharge
		tick(100, 1'b0, 16'd0, 16'd0, 14'd0, 14'd0);              // unstable, never seen stable
		tick(100, 1'b1, 16'd0, 16'd4200, 14'd4000, 14'd0);        // min cell unknown, max at limit
		tick(5000, 1'b1, 16'd3000, 16'd4200, 14'h3FFF, 14'h3FFF); // timed advance across wrap
		tick(100, 1'b1, 16'd3000, 16'd4200, 14'h3FFF, 14'h3FFF);  // overlap done, closed
		tick(10, 1'b1, 16'd3500, 16'd4201, 14'd4000, 14'd4000);   // overvolt
		issue_command(CMD_DEADMAN, 1'b0);
		issue_command(CMD_DEADMAN, 1'b1);
		tick(1, 1'b1, 16'd3500, 16'd4000, 14'd4000, 14'd0);       // precharge, stable seen
		tick(1, 1'b0, 16'd3500, 16'd4000, 14'd4000, 14'd0);       // stable lost
		issue_command(CMD_DEADMAN, 1'b0);
		issue_command(CMD_DEADMAN, 1'b1);
		tick(1, 1'b1, 16'd3500, 16'd4000, 14'd4000, 14'd0);
		tick(1, 1'b1, 16'd2999, 16'd4000, 14'd4000, 14'd0);       // undervolt

		// analog gate and coil drive on, other registers at reset values
		c = CFG_RESET;
		c.mode = 2'd3;
		apply_settings(c);
		issue_command(CMD_DEADMAN, 1'b0);
		issue_command(CMD_DEADMAN, 1'b1);
		tick(5, 1'b1, 16'd3500, 16'd4000, 14'd1000, 14'd1000);    // precharge
		tick(499, 1'b1, 16'd3500, 16'd4000, 14'd1000, 14'd1000);  // one ms short of gate_min
		tick(1, 1'b1, 16'd3500, 16'd4000, 14'd1000, 14'd898);     // ratio just short
		tick(0, 1'b1, 16'd3500, 16'd4000, 14'd1000, 14'd899);     // smallest bus that meets the ratio
		tick(100, 1'b1, 16'd3500, 16'd4000, 14'd1000, 14'd899);   // closed
		issue_command(CMD_DEADMAN, 1'b0);
		issue_command(CMD_DEADMAN, 1'b1);
		tick(1, 1'b1, 16'd3500, 16'd4000, 14'd500, 14'd500);
		tick(500, 1'b1, 16'd3500, 16'd4000, 14'd500, 14'd500);    // low pack, min bus met
		issue_command(CMD_DEADMAN, 1'b0);
		issue_command(CMD_DEADMAN, 1'b1);
		tick(1, 1'b1, 16'd3500, 16'd4000, 14'd500, 14'd499);
		tick(5000, 1'b1, 16'd3500, 16'd4000, 14'd500, 14'd499);   // precharge timeout

		// random phases, each with its own settings and idling pattern
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			apply_settings(random_settings(flavor_plan[p], mode_plan[p]));
			snd_max = (p % 3 == 0) ? 0 : 13;
			rcv_max = (p % 4 == 1) ? 0 : 13;
			if (p % 5 == 2)
				clock_ms = $urandom;
			repeat (WORDS_PER_PHASE) random_word();
		end

		drain();
		$display("%0d input words over %0d register settings, %0d result words checked",
			words_sent, settings_used, compared);
		$display("settings covered all-zero and all-max registers and every mode");
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
